// ===== rtl/khtab_pkg.sv =====
// Shared types and constants for the keyed handle table.
package khtab_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_W        = 64;
    localparam int HANDLE_W     = 64;
    localparam int COUNT_W      = 9;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FOUND     = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_SCAN      = 3'd1,
        S_MOVE_WR   = 3'd2,
        S_LOOK_WAIT = 3'd3,
        S_RESP      = 3'd4
    } state_t;

    typedef struct packed {
        status_t               status;
        logic [HANDLE_W-1:0]   found_handle;
        logic [COUNT_W-1:0]    entry_count;
    } result_t;

endpackage

// ===== rtl/khtab_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module khtab_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/khtab_ctrl.sv =====
// Operation sequencer: clears the table, or scans the key memory and then inserts, updates, moves or reads entries.
module khtab_ctrl #(
    parameter int CAPACITY = khtab_pkg::CAPACITY_DEF,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  khtab_pkg::func_t                  in_func,
    input  logic [khtab_pkg::KEY_W-1:0]       in_key,
    input  logic [khtab_pkg::HANDLE_W-1:0]    in_handle,
    output logic                              res_valid,
    input  logic                              res_ready,
    output khtab_pkg::result_t                res,
    output logic                              k_we,
    output logic [AW-1:0]                     k_waddr,
    output logic [khtab_pkg::KEY_W-1:0]       k_wdata,
    output logic [AW-1:0]                     k_raddr,
    input  logic [khtab_pkg::KEY_W-1:0]       k_rdata,
    output logic                              h_we,
    output logic [AW-1:0]                     h_waddr,
    output logic [khtab_pkg::HANDLE_W-1:0]    h_wdata,
    output logic [AW-1:0]                     h_raddr,
    input  logic [khtab_pkg::HANDLE_W-1:0]    h_rdata
);

    function automatic logic [khtab_pkg::COUNT_W-1:0] to_count(input logic [CNT_W-1:0] v);
        logic [CNT_W+khtab_pkg::COUNT_W-1:0] ext;
        ext = {{khtab_pkg::COUNT_W{1'b0}}, v};
        return ext[khtab_pkg::COUNT_W-1:0];
    endfunction

    khtab_pkg::state_t                 state_reg, state_next;
    khtab_pkg::func_t                  func_reg, func_next;
    logic [khtab_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [khtab_pkg::HANDLE_W-1:0]    handle_reg, handle_next;
    logic [CNT_W-1:0]                  fill_reg, fill_next;
    logic [CNT_W-1:0]                  idx_reg, idx_next;
    logic                              pend_reg, pend_next;
    logic [AW-1:0]                     pend_idx_reg, pend_idx_next;
    logic [AW-1:0]                     slot_reg, slot_next;
    khtab_pkg::result_t                res_reg, res_next;
    logic [CNT_W-1:0]                  last_idx;
    logic                              hit;

    assign last_idx = fill_reg - CNT_W'(1);
    assign hit      = pend_reg && (k_rdata == key_reg);
    assign res      = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= khtab_pkg::S_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
        func_reg     <= func_next;
        key_reg      <= key_next;
        handle_reg   <= handle_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        res_reg      <= res_next;
    end

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        handle_next   = handle_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        slot_next     = slot_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        k_we          = 1'b0;
        k_waddr       = slot_reg;
        k_wdata       = key_reg;
        k_raddr       = idx_reg[AW-1:0];
        h_we          = 1'b0;
        h_waddr       = slot_reg;
        h_wdata       = handle_reg;
        h_raddr       = slot_reg;

        case (state_reg)
            khtab_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    func_next   = in_func;
                    key_next    = in_key;
                    handle_next = in_handle;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    if (in_func == khtab_pkg::FUNC_CLEAR) begin
                        fill_next              = '0;
                        res_next.status        = khtab_pkg::ST_CLEARED;
                        res_next.found_handle  = '0;
                        res_next.entry_count   = '0;
                        state_next             = khtab_pkg::S_RESP;
                    end else begin
                        state_next = khtab_pkg::S_SCAN;
                    end
                end
            end
            khtab_pkg::S_SCAN: begin
                if (hit) begin
                    slot_next = pend_idx_reg;
                    pend_next = 1'b0;
                    case (func_reg)
                        khtab_pkg::FUNC_INSERT: begin
                            h_we                  = 1'b1;
                            h_waddr               = pend_idx_reg;
                            h_wdata               = handle_reg;
                            res_next.status       = khtab_pkg::ST_UPDATED;
                            res_next.found_handle = '0;
                            res_next.entry_count  = to_count(fill_reg);
                            state_next            = khtab_pkg::S_RESP;
                        end
                        khtab_pkg::FUNC_REMOVE: begin
                            k_raddr    = last_idx[AW-1:0];
                            h_raddr    = last_idx[AW-1:0];
                            state_next = khtab_pkg::S_MOVE_WR;
                        end
                        default: begin
                            h_raddr    = pend_idx_reg;
                            state_next = khtab_pkg::S_LOOK_WAIT;
                        end
                    endcase
                end else if (idx_reg < fill_reg) begin
                    k_raddr       = idx_reg[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    res_next.found_handle = '0;
                    state_next            = khtab_pkg::S_RESP;
                    if (func_reg == khtab_pkg::FUNC_INSERT) begin
                        if (fill_reg >= CNT_W'(CAPACITY)) begin
                            res_next.status      = khtab_pkg::ST_FULL;
                            res_next.entry_count = to_count(fill_reg);
                        end else begin
                            k_we                 = 1'b1;
                            k_waddr              = fill_reg[AW-1:0];
                            k_wdata              = key_reg;
                            h_we                 = 1'b1;
                            h_waddr              = fill_reg[AW-1:0];
                            h_wdata              = handle_reg;
                            fill_next            = fill_reg + CNT_W'(1);
                            res_next.status      = khtab_pkg::ST_INSERTED;
                            res_next.entry_count = to_count(fill_reg + CNT_W'(1));
                        end
                    end else begin
                        res_next.status      = khtab_pkg::ST_NOT_FOUND;
                        res_next.entry_count = to_count(fill_reg);
                    end
                end
            end
            khtab_pkg::S_MOVE_WR: begin
                k_we                  = 1'b1;
                k_waddr               = slot_reg;
                k_wdata               = k_rdata;
                h_we                  = 1'b1;
                h_waddr               = slot_reg;
                h_wdata               = h_rdata;
                fill_next             = last_idx;
                res_next.status       = khtab_pkg::ST_REMOVED;
                res_next.found_handle = '0;
                res_next.entry_count  = to_count(last_idx);
                state_next            = khtab_pkg::S_RESP;
            end
            khtab_pkg::S_LOOK_WAIT: begin
                res_next.status       = khtab_pkg::ST_FOUND;
                res_next.found_handle = h_rdata;
                res_next.entry_count  = to_count(fill_reg);
                state_next            = khtab_pkg::S_RESP;
            end
            khtab_pkg::S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = khtab_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = khtab_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/keyed_handle_table.sv =====
// Keyed handle table top level: sequencer, key and handle memories, output register.
// An insert, remove or lookup reaches the output register after a scan of the key
// memory at one entry per cycle; a clear goes there without a scan.
// One operation is in flight at a time, and the next word is accepted in the cycle after
// the result moves to the output register.
// Synchronous active-low reset zeroes the fill count; the memories are not cleared.
module keyed_handle_table #(
    parameter int CAPACITY = khtab_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_func,
    input  logic [khtab_pkg::KEY_W-1:0]       s_key,
    input  logic [khtab_pkg::HANDLE_W-1:0]    s_handle,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic [khtab_pkg::HANDLE_W-1:0]    m_found_handle,
    output logic [khtab_pkg::COUNT_W-1:0]     m_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                              res_valid;
    logic                              res_ready;
    khtab_pkg::result_t                res;
    logic                              k_we;
    logic [AW-1:0]                     k_waddr;
    logic [khtab_pkg::KEY_W-1:0]       k_wdata;
    logic [AW-1:0]                     k_raddr;
    logic [khtab_pkg::KEY_W-1:0]       k_rdata;
    logic                              h_we;
    logic [AW-1:0]                     h_waddr;
    logic [khtab_pkg::HANDLE_W-1:0]    h_wdata;
    logic [AW-1:0]                     h_raddr;
    logic [khtab_pkg::HANDLE_W-1:0]    h_rdata;
    logic                              m_valid_reg, m_valid_next;
    khtab_pkg::result_t                m_res_reg, m_res_next;

    khtab_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (khtab_pkg::func_t'(s_func)),
        .in_key    (s_key),
        .in_handle (s_handle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .k_we      (k_we),
        .k_waddr   (k_waddr),
        .k_wdata   (k_wdata),
        .k_raddr   (k_raddr),
        .k_rdata   (k_rdata),
        .h_we      (h_we),
        .h_waddr   (h_waddr),
        .h_wdata   (h_wdata),
        .h_raddr   (h_raddr),
        .h_rdata   (h_rdata)
    );

    khtab_ram #(
        .WIDTH (khtab_pkg::KEY_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    khtab_ram #(
        .WIDTH (khtab_pkg::HANDLE_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_handle_ram (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_res_reg.status;
    assign m_found_handle = m_res_reg.found_handle;
    assign m_entry_count  = m_res_reg.entry_count;

`ifndef ASSERT_OFF
    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && res_valid))
        else $error("sequencer accepts a word while a result is pending");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("pending result changed before transfer");

    a_handle_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != khtab_pkg::ST_FOUND) |-> m_found_handle == '0)
        else $error("nonzero handle without a lookup hit");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == khtab_pkg::ST_CLEARED) |-> m_entry_count == '0)
        else $error("clear left entries in the table");
`endif

endmodule

// ===== test/keyed_handle_table_tb.sv =====
// Testbench for the keyed handle table: directed and random operations checked against a model.
`timescale 1ns / 100ps

module keyed_handle_table_tb;

    localparam int DEPTH = khtab_pkg::CAPACITY_DEF;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_func = 2'd0;
    logic [khtab_pkg::KEY_W-1:0]    s_key = '0;
    logic [khtab_pkg::HANDLE_W-1:0] s_handle = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [2:0]                     m_status;
    logic [khtab_pkg::HANDLE_W-1:0] m_found_handle;
    logic [khtab_pkg::COUNT_W-1:0]  m_entry_count;

    keyed_handle_table dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_key          (s_key),
        .s_handle       (s_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_handle (m_found_handle),
        .m_entry_count  (m_entry_count)
    );

    logic [khtab_pkg::KEY_W-1:0]    tbl_keys [DEPTH];
    logic [khtab_pkg::HANDLE_W-1:0] tbl_handles [DEPTH];
    int                             tbl_fill = 0;

    khtab_pkg::result_t             pending_results [$];
    logic [khtab_pkg::KEY_W-1:0]    key_pool [$];
    int                             mismatches = 0;
    bit                             pacing_on = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int table_slot(logic [khtab_pkg::KEY_W-1:0] k);
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_keys[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic khtab_pkg::result_t apply_table_op(khtab_pkg::func_t f,
                                                          logic [khtab_pkg::KEY_W-1:0] k,
                                                          logic [khtab_pkg::HANDLE_W-1:0] h);
        khtab_pkg::result_t r;
        int                 slot;
        r.found_handle = '0;
        slot = table_slot(k);
        case (f)
            khtab_pkg::FUNC_INSERT: begin
                if (slot >= 0) begin
                    tbl_handles[slot] = h;
                    r.status = khtab_pkg::ST_UPDATED;
                end else if (tbl_fill >= DEPTH) begin
                    r.status = khtab_pkg::ST_FULL;
                end else begin
                    tbl_keys[tbl_fill] = k;
                    tbl_handles[tbl_fill] = h;
                    tbl_fill++;
                    r.status = khtab_pkg::ST_INSERTED;
                end
            end
            khtab_pkg::FUNC_REMOVE: begin
                if (slot >= 0) begin
                    tbl_keys[slot] = tbl_keys[tbl_fill-1];
                    tbl_handles[slot] = tbl_handles[tbl_fill-1];
                    tbl_fill--;
                    r.status = khtab_pkg::ST_REMOVED;
                end else begin
                    r.status = khtab_pkg::ST_NOT_FOUND;
                end
            end
            khtab_pkg::FUNC_LOOKUP: begin
                if (slot >= 0) begin
                    r.found_handle = tbl_handles[slot];
                    r.status = khtab_pkg::ST_FOUND;
                end else begin
                    r.status = khtab_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                tbl_fill = 0;
                r.status = khtab_pkg::ST_CLEARED;
            end
        endcase
        r.entry_count = tbl_fill[khtab_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_pause();
        int r;
        if (!pacing_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(khtab_pkg::func_t f, logic [khtab_pkg::KEY_W-1:0] k,
                             logic [khtab_pkg::HANDLE_W-1:0] h);
        int gap;
        gap = pick_pause();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_func   <= f;
        s_key    <= k;
        s_handle <= h;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(apply_table_op(f, k, h));
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        khtab_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: status %0d handle %h count %0d",
                             m_status, m_found_handle, m_entry_count);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_found_handle !== want.found_handle ||
                    m_entry_count !== want.entry_count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected status %0d handle %h count %0d, %s",
                                 want.status, want.found_handle, want.entry_count,
                                 $sformatf("got status %0d handle %h count %0d",
                                           m_status, m_found_handle, m_entry_count));
                    end
                end
            end
        end
    end

    initial begin : result_pacing
        int hold;
        int r;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold == 0 && pacing_on) begin
                r = $urandom_range(0, 99);
                if (r >= 97) begin
                    hold = $urandom_range(12, 60);
                end else if (r >= 75) begin
                    hold = $urandom_range(1, 3);
                end
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_basic_ops();
        logic [khtab_pkg::KEY_W-1:0] k3;
        k3 = rand64();
        send_word(khtab_pkg::FUNC_CLEAR, rand64(), rand64());
        send_word(khtab_pkg::FUNC_LOOKUP, rand64(), rand64());
        send_word(khtab_pkg::FUNC_REMOVE, rand64(), rand64());
        send_word(khtab_pkg::FUNC_INSERT, '0, '1);
        send_word(khtab_pkg::FUNC_INSERT, '1, '0);
        send_word(khtab_pkg::FUNC_LOOKUP, '0, rand64());
        // A stored handle of zero must still report a hit.
        send_word(khtab_pkg::FUNC_LOOKUP, '1, rand64());
        send_word(khtab_pkg::FUNC_INSERT, '0, 64'h5a5a_5a5a_a5a5_a5a5);
        send_word(khtab_pkg::FUNC_LOOKUP, '0, '0);
        send_word(khtab_pkg::FUNC_INSERT, k3, rand64());
        send_word(khtab_pkg::FUNC_REMOVE, '0, rand64());
        send_word(khtab_pkg::FUNC_LOOKUP, k3, '1);
        send_word(khtab_pkg::FUNC_LOOKUP, '0, rand64());
        send_word(khtab_pkg::FUNC_REMOVE, '0, rand64());
        send_word(khtab_pkg::FUNC_REMOVE, k3, rand64());
        send_word(khtab_pkg::FUNC_REMOVE, '1, rand64());
        send_word(khtab_pkg::FUNC_INSERT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_word(khtab_pkg::FUNC_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_word(khtab_pkg::FUNC_CLEAR, '1, '1);
        send_word(khtab_pkg::FUNC_LOOKUP, 64'h5555_5555_5555_5555, rand64());
    endtask

    task automatic test_full_table();
        logic [khtab_pkg::KEY_W-1:0] fresh [$];
        bit                          seen [logic [khtab_pkg::KEY_W-1:0]];
        logic [khtab_pkg::KEY_W-1:0] k;
        send_word(khtab_pkg::FUNC_CLEAR, rand64(), rand64());
        while (fresh.size() < DEPTH + 2) begin
            k = rand64();
            if (!seen.exists(k)) begin
                seen[k] = 1'b1;
                fresh.push_back(k);
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            send_word(khtab_pkg::FUNC_INSERT, fresh[i], rand64());
        end
        send_word(khtab_pkg::FUNC_INSERT, fresh[DEPTH], rand64());
        // An update still goes through when the table is full.
        send_word(khtab_pkg::FUNC_INSERT, fresh[DEPTH-1], rand64());
        send_word(khtab_pkg::FUNC_LOOKUP, fresh[DEPTH-1], rand64());
        send_word(khtab_pkg::FUNC_LOOKUP, fresh[DEPTH], rand64());
        send_word(khtab_pkg::FUNC_REMOVE, fresh[0], rand64());
        send_word(khtab_pkg::FUNC_LOOKUP, fresh[DEPTH-1], rand64());
        send_word(khtab_pkg::FUNC_INSERT, fresh[DEPTH+1], rand64());
        send_word(khtab_pkg::FUNC_LOOKUP, fresh[DEPTH+1], rand64());
        send_word(khtab_pkg::FUNC_CLEAR, rand64(), rand64());
    endtask

    task automatic run_random_ops(int count, int pool_size, int w_ins, int w_rem,
                                  int w_look, int w_clr);
        int                          r;
        khtab_pkg::func_t            f;
        logic [khtab_pkg::KEY_W-1:0] k;
        key_pool.delete();
        for (int i = 0; i < pool_size; i++) begin
            key_pool.push_back(rand64());
        end
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                pacing_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, w_ins + w_rem + w_look + w_clr - 1);
            if (r < w_ins) begin
                f = khtab_pkg::FUNC_INSERT;
            end else if (r < w_ins + w_rem) begin
                f = khtab_pkg::FUNC_REMOVE;
            end else if (r < w_ins + w_rem + w_look) begin
                f = khtab_pkg::FUNC_LOOKUP;
            end else begin
                f = khtab_pkg::FUNC_CLEAR;
            end
            if ($urandom_range(0, 99) < 12) begin
                k = rand64();
            end else begin
                k = key_pool[$urandom_range(0, pool_size - 1)];
            end
            send_word(f, k, ($urandom_range(0, 19) == 0) ? '0 : rand64());
        end
        pacing_on = 1'b1;
    endtask

    task automatic test_random_shallow();
        run_random_ops(760, 24, 35, 25, 38, 2);
    endtask

    task automatic test_random_deep();
        send_word(khtab_pkg::FUNC_CLEAR, rand64(), rand64());
        run_random_ops(420, 320, 65, 8, 27, 0);
        run_random_ops(380, 320, 22, 48, 30, 0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_basic_ops();
        test_full_table();
        test_random_shallow();
        test_random_deep();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
